[design/lds_pkg.sv]
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types and constants for the deck shuffle block: deck geometry,
// generator constants, item codes and the payload structs of both channels.
// ----------------------------------------------------------------------------
package lds_pkg;

   // Deck geometry
   localparam int CARD_COUNT = 52;
   localparam int DECK_SLOTS = 64;
   localparam int ENTRY_BITS = 64;
   localparam int SLOT_BITS  = $clog2(DECK_SLOTS);

   // Generator constants
   localparam logic [31:0] LCG_MUL = 32'd214013;
   localparam logic [31:0] LCG_ADD = 32'd2531011;

   // Item codes
   localparam logic [1:0] MODE_LOAD    = 2'd0;
   localparam logic [1:0] MODE_STEP    = 2'd1;
   localparam logic [1:0] MODE_SHUFFLE = 2'd2;

   // Input item
   typedef struct packed {
      logic [1:0]  mode;
      logic [5:0]  slot_index;
      logic [63:0] slot_value;
      logic [31:0] step_amount;
   } req_type;

   // Result item
   typedef struct packed {
      logic [5:0]  out_position;
      logic [63:0] card_entry;
      logic        last_of_run;
   } rsp_type;

   // Generator command: load a seed, add an amount, or advance one draw
   typedef struct packed {
      logic        load;
      logic        add;
      logic        advance;
      logic [31:0] operand;
   } lcg_cmd_type;

endpackage

[design/lds_deck_ram.sv]
// ----------------------------------------------------------------------------
// lds_deck_ram
// Deck slot memory: one write port, one read port with registered read data
// in the next cycle. Per-slot valid bits make unwritten slots read as blank,
// and a read of the slot being written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module lds_deck_ram import lds_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [SLOT_BITS-1:0]  wr_addr,
   input  logic [ENTRY_BITS-1:0] wr_data,
   input  logic [SLOT_BITS-1:0]  rd_addr,
   output logic [ENTRY_BITS-1:0] rd_data
);

   logic [ENTRY_BITS-1:0] mem_ff [DECK_SLOTS];
   logic [DECK_SLOTS-1:0] valid_ff;
   logic [ENTRY_BITS-1:0] q_ff;
   logic [ENTRY_BITS-1:0] fwd_ff;
   logic                  q_vld_ff;
   logic                  hit_ff;

   // Write the array and register the read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      q_ff   <= mem_ff[rd_addr];
      fwd_ff <= wr_data;
   end

   // Track written slots and same-slot collisions
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         q_vld_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         q_vld_ff <= valid_ff[rd_addr];
         hit_ff   <= wr_en && (wr_addr == rd_addr);
      end
   end

   // Forward a colliding write, blank an unwritten slot
   assign rd_data = hit_ff ? fwd_ff : (q_vld_ff ? q_ff : '0);

endmodule

[design/lds_lcg.sv]
// ----------------------------------------------------------------------------
// lds_lcg
// 32-bit linear congruential generator: seed load, additive step and one
// draw advance per command.
// ----------------------------------------------------------------------------
module lds_lcg import lds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  lcg_cmd_type cmd,
   output logic [31:0] gen_state
);

   logic [31:0] state_ff;
   logic [31:0] state_in;

   // Select the next generator value
   always_comb begin
      state_in = state_ff;
      if (cmd.load) begin
         state_in = cmd.operand;
      end else if (cmd.add) begin
         state_in = state_ff + cmd.operand;
      end else if (cmd.advance) begin
         state_in = 32'(state_ff * LCG_MUL) + LCG_ADD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign gen_state = state_ff;

endmodule

[design/lcg_deck_shuffle_compact.sv]
// ----------------------------------------------------------------------------
// lcg_deck_shuffle_compact
// Deck shuffle with compaction over a 64-slot deck memory, driven by a
// 32-bit linear congruential generator.
// ----------------------------------------------------------------------------
// Load and step items complete without leaving idle. A shuffle item keeps
// busy high: each group of four positions costs a draw state and a move
// state, which moves its eight slots in turn through the single read port
// of the deck memory; compaction then spends a read and a check state per
// upper slot visited and per blank-slot probe; the emit phase reads one slot
// per cycle, through the memory read register and the result register.
// Results appear on rsp_item with rsp_valid high for one cycle each, one per
// card position in order; the receiver cannot stall them, so it must take a
// result on every cycle that rsp_valid is high. The seed is written through
// the csr channel while the block is idle and also loads the generator.
// ----------------------------------------------------------------------------
module lcg_deck_shuffle_compact import lds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_valid,
   output rsp_type     rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_seed
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DRAW  = 4'd1;
   localparam logic [3:0] S_MOVE  = 4'd2;
   localparam logic [3:0] S_RDH   = 4'd3;
   localparam logic [3:0] S_CKH   = 4'd4;
   localparam logic [3:0] S_RDP   = 4'd5;
   localparam logic [3:0] S_CKP   = 4'd6;
   localparam logic [3:0] S_EMIT  = 4'd7;
   localparam logic [3:0] S_DRAIN = 4'd8;

   localparam int          H_FIRST_INT = (CARD_COUNT < DECK_SLOTS) ? CARD_COUNT : 0;
   localparam logic [SLOT_BITS-1:0] H_FIRST  = SLOT_BITS'(H_FIRST_INT);
   localparam logic [SLOT_BITS-1:0] LAST_POS = SLOT_BITS'(CARD_COUNT - 1);
   localparam logic [SLOT_BITS-1:0] TOP_SLOT = SLOT_BITS'(DECK_SLOTS - 1);
   localparam logic [SLOT_BITS:0]   CARDS_W  = (SLOT_BITS+1)'(CARD_COUNT);
   localparam logic                 HAS_UPPER = (CARD_COUNT < DECK_SLOTS);

   logic [3:0]            state_ff, state_in;
   logic [3:0]            mv_ff, mv_in;
   logic [SLOT_BITS-1:0]  base_ff, base_in;
   logic [SLOT_BITS-1:0]  h_ff, h_in;
   logic [SLOT_BITS-1:0]  p_ff, p_in;
   logic [SLOT_BITS-1:0]  k_ff, k_in;
   logic [ENTRY_BITS-1:0] t_ff, t_in;
   logic [ENTRY_BITS-1:0] val_ff, val_in;
   logic                  em_vld_ff, em_vld_in;
   logic [SLOT_BITS-1:0]  em_pos_ff, em_pos_in;
   logic                  em_last_ff, em_last_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic                  accept;
   logic                  wr_en;
   logic [SLOT_BITS-1:0]  wr_addr;
   logic [ENTRY_BITS-1:0] wr_data;
   logic [SLOT_BITS-1:0]  rd_addr;
   logic [ENTRY_BITS-1:0] rd_data;
   lcg_cmd_type           lcg_cmd;
   logic [31:0]           gen_state;
   logic [SLOT_BITS-1:0]  mv_src;
   logic [SLOT_BITS-1:0]  mv_dst;
   logic [2:0]            dst_sel;
   logic                  round_last;
   logic                  h_last;

   // Slot touched by each read of a round: d, i0, a, i1, b, i2, c, i3
   function automatic logic [SLOT_BITS-1:0] round_slot(
      input logic [2:0]           sel,
      input logic [31:0]          g,
      input logic [SLOT_BITS-1:0] base
   );
      logic [SLOT_BITS-1:0] slot;
      case (sel)
         3'd0:    slot = g[30:25];
         3'd1:    slot = base;
         3'd2:    slot = g[21:16];
         3'd3:    slot = base + SLOT_BITS'(1);
         3'd4:    slot = g[24:19];
         3'd5:    slot = base + SLOT_BITS'(2);
         3'd6:    slot = g[27:22];
         3'd7:    slot = base + SLOT_BITS'(3);
         default: slot = base;
      endcase
      return slot;
   endfunction

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = !busy;

   assign dst_sel    = 3'(mv_ff - 4'd2);
   assign mv_src     = round_slot(mv_ff[2:0], gen_state, base_ff);
   assign mv_dst     = round_slot(dst_sel, gen_state, base_ff);
   assign round_last = (({1'b0, base_ff} + (SLOT_BITS+1)'(4)) >= CARDS_W);
   assign h_last     = (h_ff == TOP_SLOT);

   // Generator commands: seed write, step item, one draw per round
   always_comb begin
      lcg_cmd         = '0;
      lcg_cmd.load    = csr_valid && csr_ready;
      lcg_cmd.add     = accept && (req_item.mode == MODE_STEP);
      lcg_cmd.advance = (state_ff == S_DRAW);
      lcg_cmd.operand = lcg_cmd.load ? csr_seed : req_item.step_amount;
   end

   // Sequencer: rounds of slot moves, compaction walk, emit
   always_comb begin
      state_in   = state_ff;
      mv_in      = mv_ff;
      base_in    = base_ff;
      h_in       = h_ff;
      p_in       = p_ff;
      k_in       = k_ff;
      t_in       = t_ff;
      val_in     = val_ff;
      em_vld_in  = 1'b0;
      em_pos_in  = k_ff;
      em_last_in = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = req_item.slot_index;
      wr_data    = req_item.slot_value[ENTRY_BITS-1:0];
      rd_addr    = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_item.mode == MODE_LOAD) begin
                  wr_en = 1'b1;
               end else if (req_item.mode == MODE_SHUFFLE) begin
                  base_in  = '0;
                  state_in = S_DRAW;
               end
            end
         end
         S_DRAW: begin
            mv_in    = '0;
            state_in = S_MOVE;
         end
         S_MOVE: begin
            // Read one source a cycle and write it from the registered read data
            if (mv_ff < 4'd8) begin
               rd_addr = mv_src;
            end
            if (mv_ff == 4'd1) begin
               t_in = rd_data;
            end
            if (mv_ff >= 4'd2) begin
               wr_en   = 1'b1;
               wr_addr = mv_dst;
               wr_data = (mv_ff == 4'd9) ? t_ff : rd_data;
            end
            mv_in = mv_ff + 4'd1;
            if (mv_ff == 4'd9) begin
               base_in = base_ff + SLOT_BITS'(4);
               if (!round_last) begin
                  state_in = S_DRAW;
               end else if (HAS_UPPER) begin
                  h_in     = H_FIRST;
                  p_in     = '0;
                  state_in = S_RDH;
               end else begin
                  k_in     = '0;
                  state_in = S_EMIT;
               end
            end
         end
         S_RDH: begin
            rd_addr  = h_ff;
            state_in = S_CKH;
         end
         S_CKH: begin
            if (rd_data != '0) begin
               val_in   = rd_data;
               state_in = S_RDP;
            end else if (h_last) begin
               k_in     = '0;
               state_in = S_EMIT;
            end else begin
               h_in     = h_ff + SLOT_BITS'(1);
               state_in = S_RDH;
            end
         end
         S_RDP: begin
            // No blank slot below: skip the copy
            if (p_ff == h_ff) begin
               if (h_last) begin
                  k_in     = '0;
                  state_in = S_EMIT;
               end else begin
                  h_in     = h_ff + SLOT_BITS'(1);
                  state_in = S_RDH;
               end
            end else begin
               rd_addr  = p_ff;
               state_in = S_CKP;
            end
         end
         S_CKP: begin
            if (rd_data != '0) begin
               p_in     = p_ff + SLOT_BITS'(1);
               state_in = S_RDP;
            end else begin
               wr_en   = 1'b1;
               wr_addr = p_ff;
               wr_data = val_ff;
               if (h_last) begin
                  k_in     = '0;
                  state_in = S_EMIT;
               end else begin
                  h_in     = h_ff + SLOT_BITS'(1);
                  state_in = S_RDH;
               end
            end
         end
         S_EMIT: begin
            rd_addr    = k_ff;
            em_vld_in  = 1'b1;
            em_pos_in  = k_ff;
            em_last_in = (k_ff == LAST_POS);
            if (k_ff == LAST_POS) begin
               state_in = S_DRAIN;
            end else begin
               k_in = k_ff + SLOT_BITS'(1);
            end
         end
         S_DRAIN: begin
            if (!em_vld_ff) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         em_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         em_vld_ff    <= em_vld_in;
         rsp_valid_ff <= em_vld_ff;
      end
   end

   // Counters, pointers and held data
   always_ff @(posedge clock) begin
      mv_ff      <= mv_in;
      base_ff    <= base_in;
      h_ff       <= h_in;
      p_ff       <= p_in;
      k_ff       <= k_in;
      t_ff       <= t_in;
      val_ff     <= val_in;
      em_pos_ff  <= em_pos_in;
      em_last_ff <= em_last_in;
   end

   // Register each result transfer
   always_ff @(posedge clock) begin
      if (em_vld_ff) begin
         rsp_ff.out_position <= em_pos_ff;
         rsp_ff.card_entry   <= 64'(rd_data);
         rsp_ff.last_of_run  <= em_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   lds_deck_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lds_lcg u_lcg (
      .clock     (clock),
      .reset     (reset),
      .cmd       (lcg_cmd),
      .gen_state (gen_state)
   );

endmodule
